>>> design/csvlfs_pkg.sv
// Package for the CSV line field splitter.
// Holds sizes, byte codes, the sequencer state type and the blank test.
// No dependencies.
`default_nettype none

package csvlfs_pkg;

   localparam int MAX_FIELDS = 16;
   localparam int FIELD_LEN  = 64;

   localparam int CNT_W  = (FIELD_LEN > 2) ? $clog2(FIELD_LEN) : 1;
   localparam int DEPTH  = 1 << CNT_W;
   localparam int IDX_W  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

   localparam int BYTE_W = 8;
   localparam int FNUM_W = 4;
   localparam int OFFS_W = 6;
   localparam int NF_W   = 5;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

`default_nettype wire

>>> design/csv_line_field_splitter.sv
// CSV line field splitter: takes one line byte per request and emits trimmed fields.
// Depends on csvlfs_pkg.
// Timing: an ordinary byte is taken while idle; a field close stalls requests while the field is
// walked out of the store, a store read then an output load per emitted result, and only an
// output load for an empty field. Results held by rsp_stall extend the walk.
// Throughput: one request per cycle while idle; a field close stalls requests until every result
// of the field is loaded, with a store read and an output load in turn for each non-empty result.
// Reset: synchronous, active high; clears control state. The field store is not cleared.
`default_nettype none

module csv_line_field_splitter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [csvlfs_pkg::BYTE_W-1:0] req_line_byte,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [csvlfs_pkg::BYTE_W-1:0] rsp_out_char,
   output      logic [csvlfs_pkg::FNUM_W-1:0] rsp_field_number,
   output      logic [csvlfs_pkg::OFFS_W-1:0] rsp_char_offset,
   output      logic                          rsp_field_is_empty,
   output      logic                          rsp_field_done,
   output      logic                          rsp_row_done,
   output      logic [csvlfs_pkg::NF_W-1:0]   rsp_row_fields
);

   localparam int CW = csvlfs_pkg::CNT_W;
   localparam int IW = csvlfs_pkg::IDX_W;
   localparam int BW = csvlfs_pkg::BYTE_W;

   logic [BW-1:0] store_mem [csvlfs_pkg::DEPTH];
   logic [BW-1:0] rdata_ff;

   csvlfs_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          quoted_ff, quoted_in;
   logic          skip_ff, skip_in;
   logic          any_ff, any_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;

   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] base_ff, base_in;
   logic [CW-1:0] end_ff, end_in;
   logic          empty_ff, empty_in;
   logic          last_ff, last_in;
   logic [csvlfs_pkg::FNUM_W-1:0] fnum_ff, fnum_in;
   logic [csvlfs_pkg::NF_W-1:0]   nf_ff, nf_in;

   logic                          ovalid_ff, ovalid_in;
   logic [BW-1:0]                 ochar_ff, ochar_in;
   logic [csvlfs_pkg::FNUM_W-1:0] ofnum_ff, ofnum_in;
   logic [csvlfs_pkg::OFFS_W-1:0] ooffs_ff, ooffs_in;
   logic                          oempty_ff, oempty_in;
   logic                          ofdone_ff, ofdone_in;
   logic                          ordone_ff, ordone_in;
   logic [csvlfs_pkg::NF_W-1:0]   onf_ff, onf_in;

   logic          req_fire;
   logic          out_free;
   logic          load_out;
   logic          start_emit;
   logic          field_end;
   logic          wr_en;
   logic          is_eol;
   logic [CW:0]   count_inc;
   logic [IW:0]   idx_inc;

   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !ovalid_ff || !rsp_stall;
   assign is_eol    = (req_line_byte == csvlfs_pkg::CH_NUL) ||
                      (req_line_byte == csvlfs_pkg::CH_LF)  ||
                      (req_line_byte == csvlfs_pkg::CH_CR);
   assign count_inc = {1'b0, count_ff} + (CW+1)'(1);
   assign idx_inc   = {1'b0, idx_ff} + (IW+1)'(1);
   assign field_end = empty_ff || ((ptr_ff + CW'(1)) == end_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csvlfs_pkg::ST_IDLE: begin
            if (start_emit) begin
               state_in = (!any_ff) ? csvlfs_pkg::ST_LOAD : csvlfs_pkg::ST_READ;
            end
         end
         csvlfs_pkg::ST_READ: begin
            state_in = csvlfs_pkg::ST_LOAD;
         end
         csvlfs_pkg::ST_LOAD: begin
            if (out_free) begin
               state_in = field_end ? csvlfs_pkg::ST_IDLE : csvlfs_pkg::ST_READ;
            end
         end
         default: begin
            state_in = csvlfs_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      load_out  = 1'b0;
      case (state_ff)
         csvlfs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         csvlfs_pkg::ST_READ: begin
            req_stall = 1'b1;
         end
         csvlfs_pkg::ST_LOAD: begin
            load_out = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // request decode and field bookkeeping
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      quoted_in  = quoted_ff;
      skip_in    = skip_ff;
      any_in     = any_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      ptr_in     = ptr_ff;
      base_in    = base_ff;
      end_in     = end_ff;
      empty_in   = empty_ff;
      last_in    = last_ff;
      fnum_in    = fnum_ff;
      nf_in      = nf_ff;
      start_emit = 1'b0;
      wr_en      = 1'b0;

      if (req_fire) begin
         if (skip_ff) begin
            if (is_eol) begin
               skip_in = 1'b0;
            end
         end else if (is_eol) begin
            start_emit = 1'b1;
            last_in    = 1'b1;
            nf_in      = csvlfs_pkg::NF_W'(idx_inc);
            count_in   = '0;
            idx_in     = '0;
            quoted_in  = 1'b0;
            any_in     = 1'b0;
         end else if (req_line_byte == csvlfs_pkg::CH_QUOTE) begin
            quoted_in = !quoted_ff;
         end else if ((req_line_byte == csvlfs_pkg::CH_COMMA) && !quoted_ff) begin
            start_emit = 1'b1;
            count_in   = '0;
            any_in     = 1'b0;
            if (idx_inc >= (IW+1)'(csvlfs_pkg::MAX_FIELDS)) begin
               last_in   = 1'b1;
               nf_in     = csvlfs_pkg::NF_W'(csvlfs_pkg::MAX_FIELDS);
               skip_in   = 1'b1;
               idx_in    = '0;
               quoted_in = 1'b0;
            end else begin
               last_in = 1'b0;
               nf_in   = '0;
               idx_in  = IW'(idx_inc);
            end
         end else if (count_inc < (CW+1)'(csvlfs_pkg::FIELD_LEN)) begin
            wr_en    = 1'b1;
            count_in = CW'(count_inc);
            if (!csvlfs_pkg::is_blank(req_line_byte)) begin
               hi_in  = CW'(count_inc);
               any_in = 1'b1;
               if (!any_ff) begin
                  lo_in = count_ff;
               end
            end
         end
      end

      if (start_emit) begin
         ptr_in   = lo_ff;
         base_in  = lo_ff;
         end_in   = hi_ff;
         empty_in = !any_ff;
         fnum_in  = csvlfs_pkg::FNUM_W'(idx_ff);
      end else if (load_out && !field_end) begin
         ptr_in = ptr_ff + CW'(1);
      end
   end

   // result register
   always_comb begin
      ovalid_in = ovalid_ff;
      ochar_in  = ochar_ff;
      ofnum_in  = ofnum_ff;
      ooffs_in  = ooffs_ff;
      oempty_in = oempty_ff;
      ofdone_in = ofdone_ff;
      ordone_in = ordone_ff;
      onf_in    = onf_ff;
      if (load_out) begin
         ovalid_in = 1'b1;
         ochar_in  = empty_ff ? '0 : rdata_ff;
         ofnum_in  = fnum_ff;
         ooffs_in  = empty_ff ? '0 : csvlfs_pkg::OFFS_W'(ptr_ff - base_ff);
         oempty_in = empty_ff;
         ofdone_in = field_end;
         ordone_in = last_ff;
         onf_in    = nf_ff;
      end else if (!rsp_stall) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff] <= req_line_byte;
      end
      rdata_ff <= store_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= csvlfs_pkg::ST_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         quoted_ff <= 1'b0;
         skip_ff   <= 1'b0;
         any_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         quoted_ff <= quoted_in;
         skip_ff   <= skip_in;
         any_ff    <= any_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      ptr_ff    <= ptr_in;
      base_ff   <= base_in;
      end_ff    <= end_in;
      empty_ff  <= empty_in;
      last_ff   <= last_in;
      fnum_ff   <= fnum_in;
      nf_ff     <= nf_in;
      ochar_ff  <= ochar_in;
      ofnum_ff  <= ofnum_in;
      ooffs_ff  <= ooffs_in;
      oempty_ff <= oempty_in;
      ofdone_ff <= ofdone_in;
      ordone_ff <= ordone_in;
      onf_ff    <= onf_in;
   end

   assign rsp_valid          = ovalid_ff;
   assign rsp_out_char       = ochar_ff;
   assign rsp_field_number   = ofnum_ff;
   assign rsp_char_offset    = ooffs_ff;
   assign rsp_field_is_empty = oempty_ff;
   assign rsp_field_done     = ofdone_ff;
   assign rsp_row_done       = ordone_ff;
   assign rsp_row_fields     = onf_ff;

endmodule

`default_nettype wire

>>> design/csvlfs_checker.sv
// Port-level checks for the CSV line field splitter, bound to the top level.
// Depends on csvlfs_pkg and csv_line_field_splitter.
`default_nettype none

module csvlfs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [csvlfs_pkg::BYTE_W-1:0] rsp_out_char,
   input wire logic [csvlfs_pkg::FNUM_W-1:0] rsp_field_number,
   input wire logic [csvlfs_pkg::OFFS_W-1:0] rsp_char_offset,
   input wire logic                          rsp_field_is_empty,
   input wire logic                          rsp_field_done,
   input wire logic                          rsp_row_done,
   input wire logic [csvlfs_pkg::NF_W-1:0]   rsp_row_fields
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
         $stable(rsp_char_offset) && $stable(rsp_field_done))
      else $error("stalled result changed");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_is_empty |->
         rsp_field_done && (rsp_char_offset == '0) && (rsp_out_char == '0))
      else $error("empty field result malformed");

   a_count_only_at_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_done |-> (rsp_row_fields == '0))
      else $error("field count outside row end");

   a_count_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_done |->
         (({1'b0, rsp_field_number} + csvlfs_pkg::NF_W'(1)) == rsp_row_fields))
      else $error("row field count disagrees with field number");

endmodule

bind csv_line_field_splitter csvlfs_checker u_csvlfs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_char       (rsp_out_char),
   .rsp_field_number   (rsp_field_number),
   .rsp_char_offset    (rsp_char_offset),
   .rsp_field_is_empty (rsp_field_is_empty),
   .rsp_field_done     (rsp_field_done),
   .rsp_row_done       (rsp_row_done),
   .rsp_row_fields     (rsp_row_fields)
);

`default_nettype wire
